[src/keyed_byte_stream_cipher_unit_assert.svh]
// assertion macros for the keyed byte stream cipher unit
// no dependencies; taken in by files that carry concurrent checks
`ifndef KEYED_BYTE_STREAM_CIPHER_UNIT_ASSERT_SVH
`define KEYED_BYTE_STREAM_CIPHER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// check that is switched off while reset is high
`define KBSC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("kbsc assertion failed");

// check that also holds while reset is high
`define KBSC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("kbsc assertion failed");

`else

`define KBSC_ASSERT(lbl, clk, rst, prop)
`define KBSC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[src/kbsc_pkg.sv]
// shared types and constants of the keyed byte stream cipher unit
// no dependencies; used by kbsc_mix and the top level
`default_nettype none

package kbsc_pkg;

   // opcode codes
   localparam logic OP_DATA = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   // csr register indexes
   localparam logic [1:0] CSR_MIX_KEY_A = 2'd0;
   localparam logic [1:0] CSR_MIX_KEY_B = 2'd1;
   localparam logic [1:0] CSR_MIX_KEY_C = 2'd2;
   localparam logic [1:0] CSR_MIX_KEY_D = 2'd3;

   // constant folded into msg_param for the start position
   localparam logic [7:0] START_XOR = 8'd223;

   typedef struct packed {
      logic       opcode;
      logic       decrypt_mode;
      logic [7:0] msg_param;
      logic [7:0] data_byte;
      logic       last_byte;
      logic [5:0] table_addr;
      logic [7:0] table_value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   // data item after the table read is issued
   typedef struct packed {
      logic       decrypt_mode;
      logic [7:0] msg_param;
      logic [7:0] data_byte;
      logic       last_byte;
      logic [7:0] pos;
      logic [7:0] prod_ab;
      logic [7:0] pos_mult;
   } stage_type;

endpackage

`default_nettype wire

[src/keyed_byte_stream_cipher_unit.sv]
// keyed byte stream cipher unit: top level with key table and message state
// path: an accepted data item is registered in stage 1, then in the output register
// throughput: one item per cycle while rsp_ready does not stall the output, set by the single key table read port
// reset: message state and csr registers cleared, key table not cleared
// depends on kbsc_pkg, kbsc_mix and keyed_byte_stream_cipher_unit_assert.svh
`default_nettype none

`include "keyed_byte_stream_cipher_unit_assert.svh"

module keyed_byte_stream_cipher_unit #(
   parameter int KEY_LENGTH = 64
) (
   input  var logic              clock,
   input  var logic              reset,
   // input items
   input  var logic              req_valid,
   output var logic              req_ready,
   input  var kbsc_pkg::req_type req_item,
   // result items
   output var logic              rsp_valid,
   input  var logic              rsp_ready,
   output var kbsc_pkg::rsp_type rsp_item,
   // csr write port
   input  var logic              csr_we,
   input  var logic [1:0]        csr_addr,
   input  var logic [7:0]        csr_wdata
);

   localparam int PosW  = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;
   localparam int AddrW = (PosW > 6) ? PosW : 6;
   localparam logic [7:0] PosMask = 8'(KEY_LENGTH - 1);
   localparam logic [8:0] KeyLen  = 9'(KEY_LENGTH);

   // csr registers
   logic [7:0] mix_a_ff, mix_b_ff, mix_c_ff, mix_d_ff;

   // message state
   logic [PosW-1:0] key_pos_ff, key_pos_in;
   logic [7:0]      offset_ff, offset_in;
   logic            at_start_ff, at_start_in;

   // key table, written by load items, read once per data item
   logic [7:0] key_mem [KEY_LENGTH];
   logic [7:0] key_rd_ff;

   // stage 1: table read in flight
   kbsc_pkg::stage_type s1_ff, s1_in;
   logic                s1_vld_ff, s1_vld_in;

   // output register
   kbsc_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_vld_ff, rsp_vld_in;

   logic            req_fire;
   logic            data_fire;
   logic            load_fire;
   logic            s1_adv;
   logic [7:0]      start_pos;
   logic [PosW-1:0] pos_cur;
   logic [7:0]      pos8;
   logic [7:0]      offset_cur;
   logic [7:0]      pos_sum;
   logic [7:0]      mix_cd;
   logic [AddrW-1:0] addr_wide;
   logic            addr_ok;
   logic [7:0]      mix_out;

   // handshake: stage 1 empties whenever the output register can take it
   assign s1_adv    = s1_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !s1_vld_ff || !rsp_vld_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign data_fire = req_fire && (req_item.opcode == kbsc_pkg::OP_DATA);
   assign load_fire = req_fire && (req_item.opcode == kbsc_pkg::OP_LOAD);

   // load address check: addresses past the table are dropped
   assign addr_wide = AddrW'(req_item.table_addr);
   assign addr_ok   = (9'(req_item.table_addr) < KeyLen);

   // position of the current byte; a new message takes it from msg_param
   always_comb begin
      start_pos  = (req_item.msg_param ^ kbsc_pkg::START_XOR) & PosMask;
      pos_cur    = at_start_ff ? start_pos[PosW-1:0] : key_pos_ff;
      offset_cur = at_start_ff ? 8'd0 : offset_ff;
      pos8       = 8'(pos_cur);
      pos_sum    = (pos8 + offset_cur) & PosMask;
      mix_cd     = mix_c_ff + mix_d_ff;
   end

   // next message state, moved only by data items
   always_comb begin
      key_pos_in  = key_pos_ff;
      offset_in   = offset_ff;
      at_start_in = at_start_ff;
      if (data_fire) begin
         key_pos_in  = pos_sum[PosW-1:0];
         offset_in   = req_item.last_byte ? 8'd0 : offset_cur + 8'd1;
         at_start_in = req_item.last_byte;
      end
   end

   // stage 1 load: position products are formed here to split the multiplies
   always_comb begin
      s1_in     = s1_ff;
      s1_vld_in = s1_vld_ff;
      if (data_fire) begin
         s1_in.decrypt_mode = req_item.decrypt_mode;
         s1_in.msg_param    = req_item.msg_param;
         s1_in.data_byte    = req_item.data_byte;
         s1_in.last_byte    = req_item.last_byte;
         s1_in.pos          = pos8;
         s1_in.prod_ab      = 8'(mix_a_ff * mix_b_ff);
         s1_in.pos_mult     = 8'(mix_cd * pos8);
         s1_vld_in          = 1'b1;
      end else if (s1_adv) begin
         s1_vld_in = 1'b0;
      end
   end

   kbsc_mix u_mix (
      .st       (s1_ff),
      .key_byte (key_rd_ff),
      .out_byte (mix_out)
   );

   // output register
   always_comb begin
      rsp_in     = rsp_ff;
      rsp_vld_in = rsp_vld_ff;
      if (s1_adv) begin
         rsp_in.out_byte = mix_out;
         rsp_in.out_last = s1_ff.last_byte;
         rsp_vld_in      = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_item  = rsp_ff;

   // key table port: write for loads, registered read for data items
   always_ff @(posedge clock) begin
      if (load_fire && addr_ok) begin
         key_mem[addr_wide[PosW-1:0]] <= req_item.table_value;
      end
      if (data_fire) begin
         key_rd_ff <= key_mem[pos_cur];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      rsp_ff <= rsp_in;
   end

   // control state and csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_pos_ff  <= '0;
         offset_ff   <= '0;
         at_start_ff <= 1'b1;
         s1_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         mix_a_ff    <= '0;
         mix_b_ff    <= '0;
         mix_c_ff    <= '0;
         mix_d_ff    <= '0;
      end else begin
         key_pos_ff  <= key_pos_in;
         offset_ff   <= offset_in;
         at_start_ff <= at_start_in;
         s1_vld_ff   <= s1_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         if (csr_we) begin
            unique case (csr_addr)
               kbsc_pkg::CSR_MIX_KEY_A: mix_a_ff <= csr_wdata;
               kbsc_pkg::CSR_MIX_KEY_B: mix_b_ff <= csr_wdata;
               kbsc_pkg::CSR_MIX_KEY_C: mix_c_ff <= csr_wdata;
               kbsc_pkg::CSR_MIX_KEY_D: mix_d_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // a stalled stage 1 item blocks new input
   `KBSC_ASSERT(a_stall_blocks_input, clock, reset, (s1_vld_ff && rsp_vld_ff && !rsp_ready) |-> !req_ready)
   // every accepted data item lands in stage 1
   `KBSC_ASSERT(a_data_enters_s1, clock, reset, data_fire |=> s1_vld_ff)
   // a last byte arms the next message start
   `KBSC_ASSERT(a_last_starts_msg, clock, reset, (data_fire && req_item.last_byte) |=> at_start_ff)
   // offset is zero whenever a message is about to start
   `KBSC_ASSERT(a_start_offset_zero, clock, reset, at_start_ff |-> (offset_ff == 8'd0))

endmodule

`default_nettype wire

[src/kbsc_mix.sv]
// byte combine stage: key byte, product mask, encrypt or decrypt
// depends on kbsc_pkg
`default_nettype none

module kbsc_mix (
   input  var kbsc_pkg::stage_type st,
   input  var logic [7:0]          key_byte,
   output var logic [7:0]          out_byte
);

   logic [7:0] k;
   logic [7:0] half;
   logic [7:0] kpos;
   logic [7:0] mask;
   logic [7:0] t1;
   logic [7:0] t2;

   always_comb begin
      k    = key_byte ^ st.msg_param;
      half = {1'b0, k[7:1]};
      kpos = 8'(k * st.pos);
      mask = (kpos & st.prod_ab) | st.pos_mult;
      if (st.decrypt_mode) begin
         t1       = st.data_byte ^ mask;
         t2       = t1 - half;
         out_byte = t2 ^ k;
      end else begin
         t1       = st.data_byte ^ k;
         t2       = t1 + half;
         out_byte = t2 ^ mask;
      end
   end

endmodule

`default_nettype wire

[test/tb.sv]
// self-checking testbench for keyed_byte_stream_cipher_unit
// streams key loads and data items, predicts each result in order and compares
// depends on kbsc_pkg and the rtl of keyed_byte_stream_cipher_unit
`timescale 1ns / 1ps

module tb;

   localparam int KEY_LEN = 64;
   localparam int CYCLE_LIMIT = 400000;
   // cycles to let the pipeline settle before a csr write or the final verdict
   localparam int SETTLE_CYCLES = 4;

   // decrypt_mode codes
   localparam logic MODE_ENC = 1'b0;
   localparam logic MODE_DEC = 1'b1;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   kbsc_pkg::req_type req_item = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b1;
   kbsc_pkg::rsp_type rsp_item;
   logic              csr_we = 1'b0;
   logic [1:0]        csr_addr = '0;
   logic [7:0]        csr_wdata = '0;

   // shadow of the block state used for prediction
   logic [7:0] key_shadow [KEY_LEN];
   logic [5:0] cur_pos = '0;
   logic [7:0] msg_offset = '0;
   bit         msg_start = 1'b1;
   logic [7:0] mix_a = '0, mix_b = '0, mix_c = '0, mix_d = '0;

   // enciphered or deciphered bytes still due from the block, oldest first
   kbsc_pkg::rsp_type cipher_out_q [$];

   int         fail_cnt = 0;
   int         cycle_cnt = 0;
   bit         idle_en = 1'b1;
   int         stall_cnt = 0;

   keyed_byte_stream_cipher_unit #(
      .KEY_LENGTH(KEY_LEN)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run-away guard
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result side back-pressure: rsp_ready dropped in random stall bursts of random length
   always @(posedge clock) begin
      if (stall_cnt != 0) begin
         stall_cnt <= stall_cnt - 1;
         rsp_ready <= (stall_cnt == 1);
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
         stall_cnt <= $urandom_range(1, 15);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compute the result of one accepted item, if any, and update the shadow state
   function automatic void predict_cipher(kbsc_pkg::req_type r);
      logic [7:0]        k;
      logic [7:0]        half;
      logic [7:0]        mask;
      logic [7:0]        d;
      logic [5:0]        pos;
      logic [15:0]       prod_kp;
      logic [15:0]       prod_ab;
      logic [15:0]       prod_cd;
      kbsc_pkg::rsp_type res;
      if (r.opcode == kbsc_pkg::OP_LOAD) begin
         // every 6-bit address lies inside the 64-entry table
         key_shadow[r.table_addr] = r.table_value;
         return;
      end
      // first byte of a message: start position from the parameter
      if (msg_start) begin
         cur_pos = 6'(r.msg_param ^ kbsc_pkg::START_XOR);
         msg_offset = '0;
         msg_start = 1'b0;
      end
      pos = cur_pos;
      k = key_shadow[pos] ^ r.msg_param;
      half = k >> 1;
      prod_kp = 16'(k) * 16'(pos);
      prod_ab = 16'(mix_a) * 16'(mix_b);
      prod_cd = (16'(mix_c) + 16'(mix_d)) * 16'(pos);
      mask = 8'((prod_kp & prod_ab) | prod_cd);
      if (r.decrypt_mode == MODE_ENC) begin
         d = r.data_byte ^ k;
         d = d + half;
         d = d ^ mask;
      end else begin
         d = r.data_byte ^ mask;
         d = d - half;
         d = d ^ k;
      end
      // position steps by the byte index within the message, wrapping at the table size
      cur_pos = pos + msg_offset[5:0];
      msg_offset = msg_offset + 8'd1;
      if (r.last_byte) begin
         msg_offset = '0;
         msg_start = 1'b1;
      end
      res.out_byte = d;
      res.out_last = r.last_byte;
      cipher_out_q.push_back(res);
   endfunction

   // check results first, then predict the item accepted at the same edge
   always @(posedge clock) begin
      kbsc_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (cipher_out_q.size() == 0) begin
               $error("result item with nothing expected: out_byte %0h out_last %0b",
                      rsp_item.out_byte, rsp_item.out_last);
               fail_cnt++;
            end else begin
               want = cipher_out_q.pop_front();
               if (rsp_item.out_byte !== want.out_byte) begin
                  $error("out_byte mismatch: expected %0h, actual %0h",
                         want.out_byte, rsp_item.out_byte);
                  fail_cnt++;
               end
               if (rsp_item.out_last !== want.out_last) begin
                  $error("out_last mismatch: expected %0b, actual %0b",
                         want.out_last, rsp_item.out_last);
                  fail_cnt++;
               end
            end
         end
         if (req_valid && req_ready)
            predict_cipher(req_item);
      end
   end

   // data item; the load fields are don't-care and get random content
   function automatic kbsc_pkg::req_type data_req(logic mode, logic [7:0] param,
                                                  logic [7:0] data, logic last);
      kbsc_pkg::req_type r;
      r.opcode = kbsc_pkg::OP_DATA;
      r.decrypt_mode = mode;
      r.msg_param = param;
      r.data_byte = data;
      r.last_byte = last;
      r.table_addr = 6'($urandom);
      r.table_value = 8'($urandom);
      return r;
   endfunction

   // key table load; the data fields are don't-care and get random content
   function automatic kbsc_pkg::req_type load_req(logic [5:0] addr, logic [7:0] value);
      kbsc_pkg::req_type r;
      r.opcode = kbsc_pkg::OP_LOAD;
      r.decrypt_mode = 1'($urandom);
      r.msg_param = 8'($urandom);
      r.data_byte = 8'($urandom);
      r.last_byte = 1'($urandom);
      r.table_addr = addr;
      r.table_value = value;
      return r;
   endfunction

   // present one item and return at the edge where it is taken; valid stays high
   // so a following call in the same step streams back to back
   task automatic send_req(kbsc_pkg::req_type r);
      int gap;
      if (idle_en && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid in the step of the last acceptance
   task automatic stop_req();
      req_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      // an item taken at this edge is only queued by the checker at this edge
      @(posedge clock);
      while (cipher_out_q.size() != 0) @(posedge clock);
      // loads leave no result, so give the pipeline time to finish them
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mix_key(logic [1:0] idx, logic [7:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         kbsc_pkg::CSR_MIX_KEY_A: mix_a = val;
         kbsc_pkg::CSR_MIX_KEY_B: mix_b = val;
         kbsc_pkg::CSR_MIX_KEY_C: mix_c = val;
         kbsc_pkg::CSR_MIX_KEY_D: mix_d = val;
         default: ;
      endcase
   endtask

   // new key settings, only with the block idle
   task automatic set_mix_keys(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d);
      wait_idle();
      write_mix_key(kbsc_pkg::CSR_MIX_KEY_A, a);
      write_mix_key(kbsc_pkg::CSR_MIX_KEY_B, b);
      write_mix_key(kbsc_pkg::CSR_MIX_KEY_C, c);
      write_mix_key(kbsc_pkg::CSR_MIX_KEY_D, d);
      csr_we <= 1'b0;
   endtask

   // every table entry gets a value before any data item can read it
   task automatic test_table_fill();
      for (int i = 0; i < KEY_LEN; i++)
         send_req(load_req(6'(i), 8'($urandom)));
      stop_req();
   endtask

   task automatic test_directed_messages();
      logic [7:0] p5;
      logic [7:0] p0;
      // parameters whose start positions are entries 5 and 0
      p5 = kbsc_pkg::START_XOR ^ 8'd5;
      p0 = kbsc_pkg::START_XOR;
      set_mix_keys(8'h5a, 8'hc3, 8'h11, 8'hee);
      // three-byte message starting at entry 0, byte extremes
      send_req(data_req(MODE_ENC, p0, 8'h00, 1'b0));
      send_req(data_req(MODE_ENC, p0, 8'hff, 1'b0));
      send_req(data_req(MODE_ENC, p0, 8'h80, 1'b1));
      // single-byte messages at the parameter extremes
      send_req(data_req(MODE_DEC, 8'hff, 8'hff, 1'b1));
      send_req(data_req(MODE_ENC, 8'h00, 8'h00, 1'b1));
      send_req(data_req(MODE_DEC, 8'h00, 8'hff, 1'b1));
      send_req(data_req(MODE_ENC, 8'hff, 8'h00, 1'b1));
      // mode and parameter changing within one message
      send_req(data_req(MODE_ENC, 8'h12, 8'ha5, 1'b0));
      send_req(data_req(MODE_DEC, 8'h12, 8'h5a, 1'b0));
      send_req(data_req(MODE_ENC, 8'h34, 8'h01, 1'b0));
      send_req(data_req(MODE_DEC, 8'hff, 8'hfe, 1'b1));
      // load right before and inside a message; the second byte rereads entry 5
      send_req(load_req(6'd5, 8'hff));
      send_req(data_req(MODE_ENC, p5, 8'h3c, 1'b0));
      send_req(load_req(6'd5, 8'h00));
      send_req(data_req(MODE_ENC, p5, 8'hc3, 1'b1));
      // same entry, decrypt, highest table address rewritten too
      send_req(load_req(6'd63, 8'haa));
      send_req(load_req(6'd5, 8'h81));
      send_req(data_req(MODE_DEC, p5, 8'h7e, 1'b0));
      send_req(data_req(MODE_DEC, p5, 8'h00, 1'b1));
      stop_req();
   endtask

   // mostly whole messages with random content; some with changing mode or
   // parameter, some left open, loads sprinkled in, rare long messages
   task automatic test_random_traffic(int n_items, logic [7:0] a, logic [7:0] b,
                                      logic [7:0] c, logic [7:0] d, bit idle);
      int   sent;
      int   len;
      int   roll;
      logic mode;
      logic [7:0] param;
      bit   noisy;
      bit   open_msg;
      set_mix_keys(a, b, c, d);
      idle_en = idle;
      sent = 0;
      while (sent < n_items) begin
         roll = $urandom_range(0, 19);
         if (roll == 0) begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
               send_req(load_req(6'($urandom), 8'($urandom)));
            sent += len;
         end else begin
            // long messages wrap the byte offset past the table size and past 256
            len = (roll == 1) ? $urandom_range(64, 300) : $urandom_range(1, 8);
            mode = 1'($urandom);
            param = 8'($urandom);
            noisy = (roll == 2 || roll == 3);
            open_msg = (roll == 4);
            for (int i = 0; i < len; i++) begin
               if (noisy && $urandom_range(0, 2) == 0) begin
                  mode = 1'($urandom);
                  param = 8'($urandom);
               end
               if ($urandom_range(0, 15) == 0) begin
                  send_req(load_req(6'($urandom), 8'($urandom)));
                  sent++;
               end
               send_req(data_req(mode, param, 8'($urandom), (i == len - 1) && !open_msg));
            end
            sent += len;
         end
      end
      stop_req();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_table_fill();
      test_directed_messages();
      test_random_traffic(70, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
      test_random_traffic(70, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
      test_random_traffic(70, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
      test_random_traffic(70, 8'hff, 8'h01, 8'h00, 8'hff, 1'b1);
      // final stretch at full rate on both sides
      test_random_traffic(70, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);

      // drain, then allow stray results to show up
      @(posedge clock);
      while (cipher_out_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES * 4) @(posedge clock);
      if (fail_cnt == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
